>>> rtl/core/mbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Item types and register indexes shared by the scanner and its users.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned AddrWidth = 64;
  localparam int unsigned CfgWidth  = 64;
  localparam int unsigned CareWidth = 16;
  localparam int unsigned LenWidth  = 5;

  typedef enum logic [1:0] {
    RegPatLow  = 2'd0,
    RegPatHigh = 2'd1,
    RegCare    = 2'd2,
    RegLen     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic                 first_byte;
    logic                 last_byte;
    logic [AddrWidth-1:0] region_base;
  } in_item_t;

  typedef struct packed {
    logic [AddrWidth-1:0] match_address;
    logic                 found;
  } out_item_t;

endpackage

>>> rtl/core/masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Finds the lowest offset of a wildcard byte pattern in a byte stream.
// ----------------------------------------------------------------------------
// The scanner takes one buffer byte per clock and compares a window of the
// latest bytes against the whole pattern in parallel, so it sustains one item
// per cycle while the output is not stalled. An accepted item passes an input
// register and the compare logic and lands in the result register. Each buffer
// gives at most one result: the first match address, or not found at its last
// byte. Configuration must be written by the user only while the scanner is
// idle; the scanner itself does not enforce this.
module masked_byte_pattern_scanner #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mbps_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mbps_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i
);
  import mbps_pkg::*;

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_PATTERN);

  logic [CfgWidth-1:0]  pat_lo_q, pat_hi_q;
  logic [CareWidth-1:0] care_q;
  logic [LenWidth-1:0]  len_q;

  in_item_t             in_q;
  logic                 in_vld_q;
  out_item_t            out_q;
  logic                 out_vld_q;

  logic [7:0]           win_q [MAX_PATTERN];
  logic [7:0]           win_d [MAX_PATTERN];
  logic [LW-1:0]        cnt_q, cnt_d;
  logic [AddrWidth-1:0] addr_q, addr_d;
  logic                 fin_q, fin_d;

  logic                 adv;
  logic [LW-1:0]        len_eff;
  logic [127:0]         pat_all;
  logic [LW-1:0]        cnt_base;
  logic [AddrWidth-1:0] addr_base;
  logic                 fin_base;
  logic                 hit;
  logic [AddrWidth-1:0] adj;
  logic                 res_vld;
  out_item_t            res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= '0;
      len_q    <= LenWidth'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegPatLow:  pat_lo_q <= cfg_data_i;
        RegPatHigh: pat_hi_q <= cfg_data_i;
        RegCare:    care_q   <= cfg_data_i[CareWidth-1:0];
        RegLen:     len_q    <= cfg_data_i[LenWidth-1:0];
        default:    pat_lo_q <= pat_lo_q;
      endcase
    end
  end

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || adv;
  assign pat_all    = {pat_hi_q, pat_lo_q};

  always_comb begin
    if (len_q > LenWidth'(MAX_PATTERN)) begin
      len_eff = MaxLen;
    end else begin
      len_eff = LW'(len_q);
    end
  end

  always_comb begin
    logic [LW-1:0] pos;
    cnt_base  = in_q.first_byte ? '0 : cnt_q;
    addr_base = in_q.first_byte ? in_q.region_base : addr_q;
    fin_base  = in_q.first_byte ? 1'b0 : fin_q;

    win_d[0] = in_q.data_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_d[j] = win_q[j-1];
    end
    cnt_d  = (cnt_base == MaxLen) ? MaxLen : cnt_base + LW'(1);
    addr_d = addr_base + AddrWidth'(1);

    hit = (len_eff != '0) && (cnt_d >= len_eff);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pos = len_eff - LW'(1) - LW'(i);
      if ((LW'(i) < len_eff) && care_q[i] &&
          (win_d[pos[IW-1:0]] != pat_all[8*i +: 8])) begin
        hit = 1'b0;
      end
    end

    adj = AddrWidth'(1) - AddrWidth'(len_eff);
    res_vld = 1'b0;
    res     = '0;
    fin_d   = fin_base;
    if (!fin_base) begin
      if (hit) begin
        res_vld             = 1'b1;
        res.match_address   = addr_base + adj;
        res.found           = 1'b1;
        fin_d               = 1'b1;
      end else if (in_q.last_byte) begin
        res_vld = 1'b1;
        fin_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      addr_q    <= '0;
      fin_q     <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= in_vld_q && res_vld;
      end
      if (adv && in_vld_q) begin
        fin_q <= fin_d;
        if (!fin_base) begin
          cnt_q  <= cnt_d;
          addr_q <= addr_d;
        end else begin
          cnt_q  <= cnt_base;
          addr_q <= addr_base;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (adv && in_vld_q && res_vld) begin
      out_q <= res;
    end
    if (adv && in_vld_q && !fin_base) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win_q[j] <= win_d[j];
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.found |-> out_q.match_address == '0)
    else $error("Not-found result carries a nonzero address.");

  a_fin_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(fin_q) |-> $past(adv && in_vld_q && in_q.first_byte))
    else $error("Search finished flag cleared without a new buffer.");

  a_result_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_vld_q && res_vld |=> fin_q && out_vld_q)
    else $error("Result given without marking the search finished.");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxLen)
    else $error("Byte count exceeds the window depth.");

endmodule
